FILE: sv/lrb_pkg.sv
// Shared types and constants for the low-transition row blanker.
package lrb_pkg;

    localparam int unsigned PIXEL_W = 8;
    localparam int unsigned COUNT_W = 8;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT       = 8'd255;
    localparam logic [COUNT_W-1:0] MAX_CHANGES_RESET = 8'd10;

    // Result queue behind the line store read stage.
    localparam int unsigned FIFO_DEPTH = 3;
    localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               last_in_row;
        logic               flush;
    } in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_out;
        logic               row_end;
    } out_t;

    // Per-transaction control from the row statistics to the read stage.
    typedef struct packed {
        logic emit;
        logic blank;
        logic row_end;
    } rd_ctl_t;

endpackage

FILE: sv/low_transition_row_blanker.sv
// Top level of the low-transition row blanker: handshakes, config and read stage.
// Throughput: one pixel transaction per clock while the result queue has room; each taken
// transaction reads the line store once, and writes it once unless it is a flush pixel.
// Each result belongs to the previous row, at the column of the pixel that caused it.
// Reset (aresetn low, synchronous): clears column, counters, held-row flags and the queue,
// and loads max_changes with 10; the line store keeps its contents.
module low_transition_row_blanker
    import lrb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);

    logic [COUNT_W-1:0]    max_changes_reg;
    logic                  accept;
    logic [COL_W-1:0]      column;
    rd_ctl_t               rd_ctl;
    logic [PIXEL_W-1:0]    rd_data;
    logic [FIFO_LVL_W-1:0] level;
    logic [FIFO_LVL_W:0]   in_flight;
    out_t                  push_data;

    // read stage control; the pixel itself sits in the line store output register
    logic emit_reg;
    logic blank_reg;
    logic row_end_reg;

    // Blank threshold; write it only while the block is idle (the block does not enforce this).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_changes_reg <= MAX_CHANGES_RESET;
        end else if (cfg_we) begin
            max_changes_reg <= cfg_wdata;
        end
    end

    // Take a transaction only when the queue has room for everything in flight.
    // Ready depends on registers alone, never on m_ready.
    assign in_flight = {1'b0, level} + {{FIFO_LVL_W{1'b0}}, emit_reg};
    assign s_ready   = in_flight < (FIFO_LVL_W + 1)'(FIFO_DEPTH);
    assign accept    = s_valid && s_ready;

    lrb_row_stats #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_stats (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_item     (s_data),
        .max_changes (max_changes_reg),
        .column      (column),
        .rd_ctl      (rd_ctl)
    );

    // Read the held row at this column, then overwrite it with the new data pixel.
    lrb_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .rd_en   (accept),
        .wr_en   (accept && !s_data.flush),
        .addr    (column),
        .wr_data (s_data.pixel),
        .rd_data (rd_data)
    );

    // Advance the read stage every cycle; drop the slot when nothing was taken
    // or no row was held.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_reg <= 1'b0;
        end else begin
            emit_reg <= accept && rd_ctl.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            blank_reg   <= rd_ctl.blank;
            row_end_reg <= rd_ctl.row_end;
        end
    end

    // Blank the whole held row when it had too few transitions.
    assign push_data.pixel_out = blank_reg ? '0 : rd_data;
    assign push_data.row_end   = row_end_reg;

    lrb_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit_reg),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .level     (level)
    );

    // A push never lands on a full queue unless a pop frees a slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_reg && !(m_valid && m_ready)) |-> (level < FIFO_LVL_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // Input stalls only when the queue and the read stage fill the queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (level >= FIFO_LVL_W'(FIFO_DEPTH - 1)))
        else $error("input stalled with queue space left");

    // A result comes out only for a transaction taken earlier.
    assert property (@(posedge aclk) disable iff (!aresetn)
        emit_reg |-> $past(accept))
        else $error("read stage loaded without an input transaction");

endmodule

FILE: sv/lrb_row_stats.sv
// Row statistics: column tracking, transition count and held-row decision.
module lrb_row_stats
    import lrb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 256
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  in_t                          in_item,
    input  logic [COUNT_W-1:0]           max_changes,
    output logic [$clog2(MAX_WIDTH)-1:0] column,
    output rd_ctl_t                      rd_ctl
);

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MAX_WIDTH - 1);

    logic [COL_W-1:0]   column_reg, column_next;
    logic [PIXEL_W-1:0] left_reg, left_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               held_valid_reg, held_valid_next;
    logic               held_blank_reg, held_blank_next;
    logic [COUNT_W-1:0] count_upd;

    always_comb begin
        count_upd = count_reg;
        if (!in_item.flush && (column_reg != '0) && (in_item.pixel != left_reg)
            && (count_reg != COUNT_LIMIT)) begin
            count_upd = count_reg + COUNT_W'(1);
        end
    end

    always_comb begin
        column_next     = column_reg;
        left_next       = left_reg;
        count_next      = count_reg;
        held_valid_next = held_valid_reg;
        held_blank_next = held_blank_reg;
        if (accept) begin
            if (!in_item.flush) begin
                left_next  = in_item.pixel;
                count_next = count_upd;
            end
            if (in_item.last_in_row) begin
                // close the row: hold it only if it ends on a data pixel
                held_valid_next = !in_item.flush;
                held_blank_next = !in_item.flush && (count_upd <= max_changes);
                column_next     = '0;
                count_next      = '0;
            end else if (column_reg != COL_LAST) begin
                column_next = column_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg     <= '0;
            left_reg       <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
            held_blank_reg <= 1'b0;
        end else begin
            column_reg     <= column_next;
            left_reg       <= left_next;
            count_reg      <= count_next;
            held_valid_reg <= held_valid_next;
            held_blank_reg <= held_blank_next;
        end
    end

    assign column          = column_reg;
    assign rd_ctl.emit     = held_valid_reg;
    assign rd_ctl.blank    = held_blank_reg;
    assign rd_ctl.row_end  = in_item.last_in_row;

endmodule

FILE: sv/lrb_line_store.sv
// Line buffer: one row of pixels, read-before-write at the same column.
module lrb_line_store
    import lrb_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = 256
) (
    input  logic                         aclk,
    input  logic                         rd_en,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] addr,
    input  logic [PIXEL_W-1:0]           wr_data,
    output logic [PIXEL_W-1:0]           rd_data
);

    logic [PIXEL_W-1:0] store_reg [MAX_WIDTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    // the read returns the entry's old contents when the same entry is written
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[addr];
        end
        if (wr_en) begin
            store_reg[addr] <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/lrb_out_fifo.sv
// Small result queue that decouples the result channel from the input side.
module lrb_out_fifo
    import lrb_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  out_t                  push_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    output logic [FIFO_LVL_W-1:0] level
);

    localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);

    out_t                  entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_LVL_W-1:0] level_reg, level_next;
    logic                  pop;

    assign pop = m_valid && m_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + FIFO_PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + FIFO_PTR_W'(1);
        end
        if (push && !pop) begin
            level_next = level_reg + FIFO_LVL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - FIFO_LVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign m_valid = (level_reg != '0);
    assign m_data  = entry_reg[rd_ptr_reg];
    assign level   = level_reg;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the low-transition row blanker: directed rows, then random frames.
module testbench;
    import lrb_pkg::*;

    // Line store depth of the instance; columns saturate at LINE_W-1.
    localparam int unsigned LINE_W      = 256;
    localparam int unsigned COL_W       = $clog2(LINE_W);
    // Give up after this many cycles without any transaction on either channel.
    localparam int unsigned STALL_LIMIT = 2000;
    // Cycles to let pass after the last expected result before touching the register.
    localparam int unsigned SETTLE      = 6;
    localparam int unsigned RANDOM_ITEMS = 300;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [COUNT_W-1:0] cfg_wdata = '0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    in_t                s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    out_t               m_data;

    low_transition_row_blanker dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the block state, advanced once per accepted input transaction.
    logic [PIXEL_W-1:0] line_copy [LINE_W];
    int unsigned        cur_column     = 0;
    logic [PIXEL_W-1:0] left_value     = '0;
    logic [COUNT_W-1:0] row_changes    = '0;
    logic               held_blank     = 1'b0;
    logic               row_held       = 1'b0;
    logic [COUNT_W-1:0] blank_limit    = MAX_CHANGES_RESET;

    out_t        expected_pixels [$];
    out_t        next_expected;
    in_t         row_pixels [$];
    int unsigned held_row_len   = 0;
    int unsigned counted_items  = 0;
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles    = 0;
    int unsigned ready_left     = 0;
    // Set during stretches where neither side inserts idle cycles.
    logic        back_to_back   = 1'b0;

    // Advance the shadow state by one accepted pixel; queue the output it causes.
    function automatic void predict_blanked_pixel(input in_t item);
        out_t res;
        if (row_held) begin
            res.pixel_out = held_blank ? '0 : line_copy[COL_W'(cur_column)];
            res.row_end   = item.last_in_row;
            expected_pixels = {expected_pixels, res};
        end
        if (row_held || !item.flush)
            counted_items++;
        // Flush pixels leave the store, the count and the left neighbor alone.
        if (!item.flush) begin
            if (cur_column != 0 && item.pixel != left_value && row_changes != COUNT_LIMIT)
                row_changes = row_changes + COUNT_W'(1);
            line_copy[COL_W'(cur_column)] = item.pixel;
            left_value = item.pixel;
        end
        if (item.last_in_row) begin
            // A row that ends on a flush pixel drains the buffer instead of being held.
            row_held    = !item.flush;
            held_blank  = !item.flush && (row_changes <= blank_limit);
            cur_column  = 0;
            row_changes = '0;
        end else if (cur_column < LINE_W - 1) begin
            cur_column++;
        end
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (back_to_back || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic void add_pixel(input logic [PIXEL_W-1:0] value, input logic last,
                                      input logic fl);
        in_t item;
        item.pixel       = value;
        item.last_in_row = last;
        item.flush       = fl;
        row_pixels = {row_pixels, item};
    endfunction

    // Build a row in row_pixels: either random bytes, or a two-level row with exactly
    // 'toggles' level changes. flush_pct sets the share of flush pixels before the last.
    function automatic void fill_row(input int unsigned len, input int unsigned toggles,
                                     input logic [PIXEL_W-1:0] lo, input logic [PIXEL_W-1:0] hi,
                                     input int unsigned flush_pct, input logic flush_last,
                                     input logic random_bytes);
        logic [PIXEL_W-1:0] level;
        logic [PIXEL_W-1:0] value;
        int unsigned        done;
        logic               last;
        row_pixels.delete();
        level = lo;
        done  = 0;
        if (toggles > len - 1)
            toggles = len - 1;
        for (int unsigned i = 0; i < len; i++) begin
            if (random_bytes) begin
                value = PIXEL_W'($urandom_range(0, 255));
            end else begin
                // Spread the remaining level changes over the remaining positions.
                if (i > 0 && $urandom_range(1, len - i) <= toggles - done) begin
                    level = (level == lo) ? hi : lo;
                    done++;
                end
                value = level;
            end
            last = (i == len - 1);
            add_pixel(value, last, last ? flush_last : ($urandom_range(0, 99) < flush_pct));
        end
    endfunction

    // Offer one pixel and hold it until the block takes it.
    task automatic send_pixel(input in_t item);
        int unsigned gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        predict_blanked_pixel(item);
    endtask

    // Drop valid, wait for every queued result, then let the pipeline settle.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Send row_pixels; now and then pause mid-row until the output side catches up.
    task automatic send_row();
        int pause_at;
        pause_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, row_pixels.size() - 1) : -1;
        for (int i = 0; i < row_pixels.size(); i++) begin
            send_pixel(row_pixels[i]);
            if (i == pause_at)
                wait_drained();
        end
        if (!row_pixels[row_pixels.size() - 1].flush)
            held_row_len = row_pixels.size();
    endtask

    task automatic send_flush_row(input int unsigned len);
        fill_row(len, 0, '0, '0, 100, 1'b1, 1'b1);
        send_row();
    endtask

    task automatic write_max_changes(input logic [COUNT_W-1:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        blank_limit = value;
    endtask

    // Rows right at and just above the reset limit of ten transitions.
    task automatic test_transition_threshold();
        fill_row(12, 10, 8'h00, 8'hFF, 0, 1'b0, 1'b0);
        send_row();
        fill_row(12, 11, 8'h00, 8'hFF, 0, 1'b0, 1'b0);
        send_row();
        send_flush_row(12);
    endtask

    // One-pixel rows have no transitions and are always blanked.
    task automatic test_one_pixel_rows();
        send_flush_row(1);
        fill_row(1, 0, 8'hFF, 8'h00, 0, 1'b0, 1'b0);
        send_row();
        fill_row(1, 0, 8'h00, 8'hFF, 0, 1'b0, 1'b0);
        send_row();
        send_flush_row(1);
    endtask

    // Flush pixels inside a data row, a data row that ends on a flush pixel,
    // and flush rows while nothing is held.
    task automatic test_flush_inside_row();
        write_max_changes(8'd0);
        fill_row(4, 3, 8'h0F, 8'hF0, 0, 1'b0, 1'b0);
        send_row();
        row_pixels.delete();
        add_pixel(8'hAA, 1'b0, 1'b0);
        add_pixel(8'h55, 1'b0, 1'b1);
        add_pixel(8'h55, 1'b0, 1'b0);
        add_pixel(8'hAA, 1'b1, 1'b0);
        send_row();
        row_pixels.delete();
        add_pixel(8'h01, 1'b0, 1'b0);
        add_pixel(8'h02, 1'b0, 1'b0);
        add_pixel(8'h03, 1'b0, 1'b0);
        add_pixel(8'h00, 1'b1, 1'b1);
        send_row();
        send_flush_row(3);
        fill_row(4, 0, 8'h3C, 8'hC3, 0, 1'b0, 1'b0);
        send_row();
        send_flush_row(4);
    endtask

    // Largest limit blanks everything; zero blanks only flat rows.
    task automatic test_register_extremes();
        write_max_changes(8'd255);
        fill_row(6, 5, 8'h00, 8'hFF, 0, 1'b0, 1'b0);
        send_row();
        send_flush_row(6);
        write_max_changes(8'd0);
        fill_row(5, 0, 8'h7E, 8'h81, 0, 1'b0, 1'b0);
        send_row();
        fill_row(5, 1, 8'h7E, 8'h81, 0, 1'b0, 1'b0);
        send_row();
        send_flush_row(5);
    endtask

    // A row longer than the store: the column sticks at the last entry and the
    // transition count saturates. This also fills every entry of the store.
    // The short drain row reads the first entries, which a wrapping column would overwrite.
    task automatic test_overlong_rows();
        write_max_changes(8'd254);
        fill_row(LINE_W + 4, 0, '0, '0, 0, 1'b0, 1'b1);
        send_row();
        send_flush_row(8);
    endtask

    function automatic logic [COUNT_W-1:0] pick_max_changes();
        case ($urandom_range(0, 5))
            0: return 8'd0;
            1: return 8'd255;
            2, 3: return COUNT_W'($urandom_range(0, 15));
            4: return MAX_CHANGES_RESET;
            default: return COUNT_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Aim the transition count at the current limit, or anywhere.
    function automatic int unsigned pick_toggles(input int unsigned len);
        int unsigned t;
        case ($urandom_range(0, 4))
            0: t = 32'(blank_limit);
            1: t = 32'(blank_limit) + 1;
            2: t = (blank_limit > 0) ? 32'(blank_limit) - 1 : 0;
            3: t = 0;
            default: t = $urandom_range(0, len - 1);
        endcase
        return (t > len - 1) ? len - 1 : t;
    endfunction

    // Random frames of rows no wider than the frame width, each frame closed by draining the buffer.
    // A row never outruns the held row, so every read hits a written entry.
    task automatic test_random_frames();
        int unsigned start_count;
        int unsigned width;
        int unsigned rows;
        int unsigned len;
        int unsigned r;
        logic [PIXEL_W-1:0] lo;
        logic [PIXEL_W-1:0] hi;
        start_count = counted_items;
        while (counted_items - start_count < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0)
                write_max_changes(pick_max_changes());
            back_to_back = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 80)
                width = $urandom_range(1, 16);
            else
                width = $urandom_range(17, 48);
            // Noise: flush pixels while nothing is held cause no output.
            if ($urandom_range(0, 9) == 0)
                send_flush_row($urandom_range(1, 8));
            rows = $urandom_range(1, 6);
            for (int unsigned k = 0; k < rows; k++) begin
                len = width;
                if (row_held) begin
                    if (len > held_row_len || $urandom_range(0, 4) == 0)
                        len = $urandom_range(1, held_row_len);
                end
                case ($urandom_range(0, 3))
                    0: begin lo = 8'h00; hi = 8'hFF; end
                    1: begin lo = 8'h00; hi = 8'h01; end
                    default: begin
                        lo = PIXEL_W'($urandom_range(0, 255));
                        hi = lo ^ 8'($urandom_range(1, 255));
                    end
                endcase
                fill_row(len, pick_toggles(len), lo, hi,
                         ($urandom_range(0, 9) == 0) ? 20 : 0, 1'b0,
                         $urandom_range(0, 3) == 0);
                send_row();
            end
            // Close the frame: a flush row, or a data row that ends on a flush pixel.
            len = ($urandom_range(0, 2) == 0) ? $urandom_range(1, held_row_len) : held_row_len;
            if ($urandom_range(0, 3) == 0) begin
                fill_row(len, pick_toggles(len), 8'h00, 8'hFF, 0, 1'b1, 1'b0);
                send_row();
            end else begin
                send_flush_row(len);
            end
        end
        back_to_back = 1'b0;
    endtask

    // Output side: alternate ready runs with stalls, none during back-to-back stretches.
    always @(negedge aclk) begin
        if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if (m_ready && !back_to_back) begin
            m_ready    <= 1'b0;
            ready_left <= pick_gap();
        end else begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 12);
        end
    end

    // Compare each output transaction with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $error("unexpected result: pixel_out %0d row_end %0b",
                       m_data.pixel_out, m_data.row_end);
                mismatch_count++;
            end else begin
                next_expected = expected_pixels.pop_front();
                if (m_data.pixel_out !== next_expected.pixel_out) begin
                    $error("pixel_out: expected %0d, got %0d",
                           next_expected.pixel_out, m_data.pixel_out);
                    mismatch_count++;
                end
                if (m_data.row_end !== next_expected.row_end) begin
                    $error("row_end: expected %0b, got %0b",
                           next_expected.row_end, m_data.row_end);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_transition_threshold();
        test_one_pixel_rows();
        test_flush_inside_row();
        test_register_extremes();
        test_overlong_rows();
        test_random_frames();

        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        if (expected_pixels.size() != 0)
            $error("%0d expected results never arrived", expected_pixels.size());
        if (mismatch_count == 0 && expected_pixels.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
sv/lrb_pkg.sv
sv/lrb_row_stats.sv
sv/lrb_line_store.sv
sv/lrb_out_fifo.sv
sv/low_transition_row_blanker.sv
test/testbench.sv
